FILE: rtl/tli_pkg.sv
// package for the table linear interpolator
// holds the controller states, request and status codes and fixed field widths
// no dependencies
package tli_pkg;

    // fixed widths of the beat fields and of num_points
    localparam int unsigned COORD_W = 32;
    localparam int unsigned NUM_W   = 9;
    localparam int unsigned IDX_W   = 8;

    // restoring divider runs one quotient bit per cycle over the 64-bit product
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned DIV_STEPS = 64;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_CLAMP  = 2'd1,
        ST_HIT    = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_MUL0,
        S_MUL1,
        S_DIV,
        S_FIX,
        S_OUT
    } t_state;

endpackage

FILE: rtl/tli_if.sv
// valid/ready channel interfaces for the table linear interpolator
// tli_in_if carries load and query beats, tli_out_if carries result beats
// no dependencies
interface tli_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic        [7:0]  point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] value_y;

    modport source (output valid, output func, output point_index, output coord_x,
                    output value_y, input ready);
    modport sink   (input valid, input func, input point_index, input coord_x,
                    input value_y, output ready);
endinterface

interface tli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_y;
    logic        [1:0]  status;

    modport source (output valid, output result_y, output status, input ready);
    modport sink   (input valid, input result_y, input status, output ready);
endinterface

FILE: rtl/table_linear_interpolator_core.sv
// table linear interpolator: point memory, scan controller, multiplier and divider
// depends on tli_pkg and the channel interfaces in tli_if.sv
//
// usage
//   i_in carries one beat per request. func load writes (coord_x, value_y) into
//   entry point_index and gives no result. func query scans entries 0 .. n-1,
//   n = min(num_points, MAX_POINTS), for the nearest x below and above coord_x,
//   and returns one beat on o_out with the interpolated, clamped or exact-hit y and a status.
//   i_cfg_we/i_cfg_wdata write num_points; write it only while the block is idle.
// sequence
//   the scan reads one entry per cycle through the single read port; the pick,
//   multiply (S_MUL0, S_MUL1), divider and saturate (S_FIX) states and the output
//   register follow for an interpolated result. A clamped or hit result goes from
//   the pick state straight to the output register, and an empty-table result skips
//   the scan as well. i_in.ready returns with the result, and loads keep it high.
// reset
//   clears num_points, the controller and the output valid; table contents are
//   undefined until loaded.
// stall
//   a finished result waits in the output register while loads are still taken;
//   the next query result holds in the controller until o_out.ready frees it.
module table_linear_interpolator_core #(
    parameter int unsigned MAX_POINTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tli_pkg::NUM_W-1:0]   i_cfg_wdata,
    tli_in_if.sink                      i_in,
    tli_out_if.source                   o_out
);
    import tli_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = (AW + 1 > NUM_W) ? AW + 1 : NUM_W;
    localparam int unsigned EW = 2 * COORD_W;

    // point memory, one word per entry: {x, y}
    logic [EW-1:0]              r_mem [MAX_POINTS];
    logic [EW-1:0]              r_rd_data;

    logic [NUM_W-1:0]           r_num_points;
    t_state                     r_state, n_state;
    logic [CW-1:0]              r_cnt;
    logic                       r_pend;

    logic signed [COORD_W-1:0]  r_qx;
    logic                       r_lo_v, r_hi_v, r_hit_v;
    logic signed [COORD_W-1:0]  r_lo_x, r_lo_y, r_hi_x, r_hi_y, r_hit_y;

    logic [COORD_W:0]           r_mag;
    logic                       r_neg;
    logic [COORD_W-1:0]         r_t;
    logic [COORD_W-1:0]         r_den;
    logic [PROD_W-1:0]          r_prod;
    logic [COORD_W-1:0]         r_rem;

    logic signed [COORD_W-1:0]  r_res_y;
    t_status                    r_res_st;

    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_y;
    logic [1:0]                 r_out_st;

    logic [CW-1:0]              w_n_eff;
    logic [CW-1:0]              w_num_ext;
    logic [CW-1:0]              w_max;
    logic [CW-1:0]              w_idx_ext;
    logic                       w_in_acc;
    logic                       w_query;
    logic                       w_mem_we;
    logic                       w_issue;
    logic                       w_out_load;
    logic signed [COORD_W-1:0]  w_xi, w_yi;
    logic signed [COORD_W:0]    w_dy;
    logic signed [COORD_W:0]    w_tx, w_dx;
    logic [48:0]                w_pp;
    logic [COORD_W:0]           w_trial;
    logic [COORD_W:0]           w_diff;
    logic                       w_ge;
    logic signed [COORD_W+2:0]  w_sum;
    logic signed [COORD_W-1:0]  w_sat;

    // effective entry count and load range check
    assign w_num_ext = CW'(r_num_points);
    assign w_max     = CW'(MAX_POINTS);
    assign w_n_eff   = (w_num_ext > w_max) ? w_max : w_num_ext;
    assign w_idx_ext = CW'(i_in.point_index);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_query    = (i_in.func == FUNC_QUERY);
    assign w_mem_we   = w_in_acc && !w_query && (w_idx_ext < w_max);
    assign w_issue    = (r_state == S_SCAN) && (r_cnt < w_n_eff);

    // point memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_idx_ext[AW-1:0]] <= {i_in.coord_x, i_in.value_y};
        end
        r_rd_data <= r_mem[r_cnt[AW-1:0]];
    end

    assign w_xi = r_rd_data[EW-1:COORD_W];
    assign w_yi = r_rd_data[COORD_W-1:0];

    // neighbor differences
    assign w_dy = {r_hi_y[COORD_W-1], r_hi_y} - {r_lo_y[COORD_W-1], r_lo_y};
    assign w_tx = {r_qx[COORD_W-1], r_qx} - {r_lo_x[COORD_W-1], r_lo_x};
    assign w_dx = {r_hi_x[COORD_W-1], r_hi_x} - {r_lo_x[COORD_W-1], r_lo_x};

    // shared 33x16 partial product
    assign w_pp = r_mag * ((r_state == S_MUL0) ? r_t[15:0] : r_t[31:16]);

    // restoring divider step
    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // signed sum and saturation
    always_comb begin
        if (r_neg) begin
            w_sum = (COORD_W+3)'(r_lo_y) - $signed({2'b00, r_prod[COORD_W:0]});
        end else begin
            w_sum = (COORD_W+3)'(r_lo_y) + $signed({2'b00, r_prod[COORD_W:0]});
        end
        if (w_sum[COORD_W+2:COORD_W-1] == '0 || w_sum[COORD_W+2:COORD_W-1] == '1) begin
            w_sat = w_sum[COORD_W-1:0];
        end else if (w_sum[COORD_W+2]) begin
            w_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    // controller next state
    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_query) begin
                    n_state = (w_n_eff == '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_pend) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_hit_v || !r_lo_v || !r_hi_v) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_points <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num_points <= i_cfg_wdata;
            end
            r_pend <= w_issue;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt   <= '0;
                r_qx    <= i_in.coord_x;
                r_lo_v  <= 1'b0;
                r_hi_v  <= 1'b0;
                r_hit_v <= 1'b0;
                r_res_y  <= '0;
                r_res_st <= ST_EMPTY;
            end
            S_SCAN: begin
                if (w_issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                // compare the beat read last cycle; first index wins ties
                if (r_pend) begin
                    if (w_xi == r_qx) begin
                        if (!r_hit_v) begin
                            r_hit_v <= 1'b1;
                            r_hit_y <= w_yi;
                        end
                    end else if (w_xi < r_qx) begin
                        if (!r_lo_v || w_xi > r_lo_x) begin
                            r_lo_v <= 1'b1;
                            r_lo_x <= w_xi;
                            r_lo_y <= w_yi;
                        end
                    end else begin
                        if (!r_hi_v || w_xi < r_hi_x) begin
                            r_hi_v <= 1'b1;
                            r_hi_x <= w_xi;
                            r_hi_y <= w_yi;
                        end
                    end
                end
            end
            S_PICK: begin
                r_cnt <= '0;
                r_neg <= w_dy[COORD_W];
                r_mag <= w_dy[COORD_W] ? (COORD_W+1)'(-w_dy) : (COORD_W+1)'(w_dy);
                r_t   <= w_tx[COORD_W-1:0];
                r_den <= w_dx[COORD_W-1:0];
                r_rem <= '0;
                if (r_hit_v) begin
                    r_res_y  <= r_hit_y;
                    r_res_st <= ST_HIT;
                end else begin
                    r_res_y  <= r_lo_v ? r_lo_y : r_hi_y;
                    r_res_st <= ST_CLAMP;
                end
            end
            S_MUL0: begin
                r_prod <= PROD_W'(w_pp);
            end
            S_MUL1: begin
                r_prod <= r_prod + {w_pp[47:0], 16'b0};
            end
            S_DIV: begin
                r_cnt  <= r_cnt + 1'b1;
                r_rem  <= w_ge ? w_diff[COORD_W-1:0] : w_trial[COORD_W-1:0];
                r_prod <= {r_prod[PROD_W-2:0], w_ge};
            end
            S_FIX: begin
                r_res_y  <= w_sat;
                r_res_st <= ST_INTERP;
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_out_y  <= r_res_y;
                    r_out_st <= r_res_st;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.result_y = r_out_y;
    assign o_out.status   = r_out_st;

    // checks on the controller and datapath
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_neighbors_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_lo_v && r_hi_v) |-> (r_lo_x < r_qx && r_qx < r_hi_x))
        else $error("neighbors do not bracket query x");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= w_n_eff))
        else $error("scan address past entry count");

    a_pend_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == S_SCAN))
        else $error("read beat pending outside scan");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> (r_state == S_OUT))
        else $error("result left controller while output stalled");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for table_linear_interpolator_core
// depends on tli_pkg, tli_in_if / tli_out_if and the core; checks every query result
module testbench;
    import tli_pkg::*;

    localparam int unsigned MAX_PTS       = 256;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct {
        t_func              func;
        logic        [7:0]  point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] value_y;
    } t_lq_beat;

    typedef struct packed {
        logic signed [31:0] result_y;
        t_status            status;
    } t_interp_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             num_points_we;
    logic [NUM_W-1:0] num_points_wdata;

    tli_in_if  in_if ();
    tli_out_if out_if ();

    table_linear_interpolator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (num_points_we),
        .i_cfg_wdata (num_points_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // stimulus side
    t_lq_beat           pending_beats_q[$];
    logic signed [31:0] stim_x[MAX_PTS];
    bit                 stim_loaded[MAX_PTS];
    int unsigned        beats_pushed;
    int                 sender_idle_pct;
    int                 recv_stall_pct;
    int unsigned        hold_req_cnt;
    int unsigned        cfg_writes;

    // predictor side
    logic signed [31:0] tbl_x[MAX_PTS];
    logic signed [31:0] tbl_y[MAX_PTS];
    logic [NUM_W-1:0]   num_pts_shadow;
    t_interp_result     expected_results_q[$];
    int unsigned        beats_taken;
    int unsigned        loads_seen;
    int unsigned        queries_seen;
    int unsigned        results_checked;
    int unsigned        mismatches;
    logic               in_fire;

    // receiver hold-off bookkeeping
    int unsigned        hold_ack_cnt;
    int unsigned        hold_left;
    int unsigned        quiet_cycles;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // expected result of a query against the predictor's table copy
    function automatic t_interp_result interpolate_at(input logic signed [31:0] qx);
        t_interp_result r;
        int unsigned    span;
        int             lo;
        int             hi;
        int             hit;
        int             k;
        longint         xq;
        longint         xi;
        longint         xlo;
        longint         xhi;
        longint         y0;
        longint         y1;
        longint         dy;
        longint         sum;
        bit [63:0]      mag;
        bit [63:0]      t;
        bit [63:0]      d;
        bit [63:0]      q;
        span = (num_pts_shadow > MAX_PTS) ? MAX_PTS : num_pts_shadow;
        lo = -1;
        hi = -1;
        hit = -1;
        xlo = 0;
        xhi = 0;
        xq = longint'(qx);
        r.result_y = '0;
        r.status = ST_EMPTY;
        if (span == 0) return r;
        for (int i = 0; i < span; i++) begin
            xi = longint'(tbl_x[i]);
            if (xi == xq) begin
                if (hit < 0) hit = i;
            end else if (xi < xq) begin
                if (lo < 0 || xi > xlo) begin
                    lo = i;
                    xlo = xi;
                end
            end else begin
                if (hi < 0 || xi < xhi) begin
                    hi = i;
                    xhi = xi;
                end
            end
        end
        if (hit >= 0) begin
            r.result_y = tbl_y[hit];
            r.status = ST_HIT;
            return r;
        end
        if (lo < 0 || hi < 0) begin
            k = (lo < 0) ? hi : lo;
            r.result_y = tbl_y[k];
            r.status = ST_CLAMP;
            return r;
        end
        // y0 + trunc(dy * (x - x0) / (x1 - x0)), magnitude form, then saturate
        y0 = longint'(tbl_y[lo]);
        y1 = longint'(tbl_y[hi]);
        dy = y1 - y0;
        t = xq - xlo;
        d = xhi - xlo;
        mag = (dy < 0) ? -dy : dy;
        q = (mag * t) / d;
        sum = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        r.result_y = sum[31:0];
        r.status = ST_INTERP;
        return r;
    endfunction

    // x value for a loaded point: 0 tight with many ties, 1 moderate, 2 full range
    function automatic logic signed [31:0] draw_coord(input int style);
        case (style)
            0: return (int'($urandom_range(0, 8)) - 4) * 65536;
            1: return int'($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
            default: return $urandom();
        endcase
    endfunction

    // query x aimed at hits, near misses, gaps and the extremes
    function automatic logic signed [31:0] pick_query_x(input int unsigned n_eff,
                                                         input int style);
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(99);
        if (n_eff == 0) return $urandom();
        k = $urandom_range(n_eff - 1);
        if (sel < 30) return stim_x[k];
        if (sel < 50) return stim_x[k] + int'($urandom_range(0, 6)) - 3;
        if (sel < 60) return stim_x[k] + int'($urandom_range(0, 131072)) - 65536;
        if (sel < 72) return $urandom();
        if (sel < 82) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return draw_coord(style);
    endfunction

    task automatic push_load(input logic [7:0] idx, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        t_lq_beat b;
        b.func = FUNC_LOAD;
        b.point_index = idx;
        b.coord_x = x;
        b.value_y = y;
        stim_x[idx] = x;
        stim_loaded[idx] = 1'b1;
        pending_beats_q.push_back(b);
        beats_pushed++;
    endtask

    task automatic push_query(input logic signed [31:0] x);
        t_lq_beat b;
        b.func = FUNC_QUERY;
        b.point_index = 8'($urandom());
        b.coord_x = x;
        b.value_y = $urandom();
        pending_beats_q.push_back(b);
        beats_pushed++;
    endtask

    // wait until every beat is taken and every result is back, then let the core settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (beats_pushed != beats_taken || expected_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_num_points(input logic [NUM_W-1:0] v);
        num_points_we <= 1'b1;
        num_points_wdata <= v;
        num_pts_shadow = v;
        cfg_writes++;
        @(negedge i_clk);
        num_points_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] draw_y();
        if ($urandom_range(99) < 75) return $urandom();
        return draw_coord(1);
    endfunction

    task automatic run_phase(input int unsigned cfg, input int sidle, input int rstall,
                             input int count, input int style, input bit hold);
        int unsigned n_eff;
        logic [7:0]  idx;
        wait_idle();
        write_num_points(NUM_W'(cfg));
        sender_idle_pct = sidle;
        recv_stall_pct = rstall;
        if (hold) hold_req_cnt++;
        n_eff = (cfg > MAX_PTS) ? MAX_PTS : cfg;
        // every entry a query scans must be loaded first
        for (int i = 0; i < n_eff; i++)
            if (!stim_loaded[i]) push_load(8'(i), draw_coord(style), draw_y());
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(99) < 25) begin
                if (n_eff > 0 && $urandom_range(99) < 70) idx = 8'($urandom_range(n_eff - 1));
                else idx = 8'($urandom_range(255));
                push_load(idx, draw_coord(style), draw_y());
            end else begin
                push_query(pick_query_x(n_eff, style));
            end
        end
    endtask

    // input driver: next beat from the pending queue, random sender gaps
    always @(negedge i_clk) begin
        t_lq_beat b;
        if (i_rst_n && (!in_if.valid || in_fire)) begin
            if (pending_beats_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                b = pending_beats_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.func <= b.func;
                in_if.point_index <= b.point_index;
                in_if.coord_x <= b.coord_x;
                in_if.value_y <= b.value_y;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        logic rdy;
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_left = HOLD_CYCLES;
            hold_ack_cnt = hold_req_cnt;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            rdy = ($urandom_range(99) >= recv_stall_pct);
        end
        out_if.ready <= rdy;
    end

    // monitor: check result beats, predict on accepted input beats
    always @(posedge i_clk) begin
        t_interp_result want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (expected_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: y=%h status=%0d",
                                 out_if.result_y, out_if.status);
                end else begin
                    want = expected_results_q.pop_front();
                    results_checked++;
                    if (out_if.result_y !== want.result_y || out_if.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result mismatch: expected y=%h status=%s, %s",
                                     want.result_y, want.status.name(),
                                     $sformatf("got y=%h status=%0d",
                                               out_if.result_y, out_if.status));
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                beats_taken++;
                if (in_if.func == FUNC_LOAD) begin
                    tbl_x[in_if.point_index] = in_if.coord_x;
                    tbl_y[in_if.point_index] = in_if.value_y;
                    loads_seen++;
                end else begin
                    expected_results_q.push_back(interpolate_at(in_if.coord_x));
                    queries_seen++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        num_points_we = 1'b0;
        num_points_wdata = '0;
        in_if.valid = 1'b0;
        in_if.func = FUNC_LOAD;
        in_if.point_index = '0;
        in_if.coord_x = '0;
        in_if.value_y = '0;
        out_if.ready = 1'b0;
        num_pts_shadow = '0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req_cnt = 0;
        hold_ack_cnt = 0;
        hold_left = 0;
        quiet_cycles = 0;
        beats_pushed = 0;
        beats_taken = 0;
        loads_seen = 0;
        queries_seen = 0;
        results_checked = 0;
        mismatches = 0;
        cfg_writes = 0;
        for (int i = 0; i < MAX_PTS; i++) stim_loaded[i] = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table straight after reset
        push_query(32'sh8000_0000);
        push_query(32'sh7fff_ffff);
        // extreme points, a duplicated x, and the top index
        push_load(8'd0, 32'sh8000_0000, 32'sh7fff_ffff);
        push_load(8'd1, 32'sh7fff_ffff, 32'sh8000_0000);
        push_load(8'd2, 32'sh0, 32'sh0001_0000);
        push_load(8'd3, 32'sh0, 32'sh0000_0005);
        push_load(8'd255, 32'sh1234_5678, 32'shffff_ffff);
        // full-span interpolation and hits on both extremes
        wait_idle();
        write_num_points(2);
        push_query(32'sh0);
        push_query(32'sh8000_0000);
        push_query(32'sh7fff_ffff);
        // hit with a tie on x, interpolation across the widest gaps
        wait_idle();
        write_num_points(4);
        push_query(32'sh0);
        push_query(32'sh1);
        push_query(-32'sd1);
        // single point: clamp from either side, then a hit
        push_load(8'd0, 32'sh0005_0000, 32'sh0003_0000);
        push_load(8'd1, 32'sh0005_0000, 32'shfffd_0000);
        wait_idle();
        write_num_points(1);
        push_query(32'sh7fff_ffff);
        push_query(32'sh8000_0000);
        push_query(32'sh0005_0000);
        // ties on both the lower and upper neighbor
        wait_idle();
        write_num_points(4);
        push_query(32'sh0001_0000);

        // random phases: table size, sender idle, receiver stall, beats, x style, hold
        run_phase(3,   0,  0,  100, 0, 1'b0);
        run_phase(8,   88, 0,  110, 1, 1'b0);
        run_phase(16,  0,  88, 110, 0, 1'b0);
        run_phase(2,   15, 15, 110, 2, 1'b0);
        run_phase(0,   0,  0,  30,  1, 1'b0);
        run_phase(5,   0,  0,  110, 0, 1'b1);
        run_phase(256, 0,  0,  100, 1, 1'b0);
        run_phase(40,  88, 0,  110, 2, 1'b0);
        run_phase(1,   0,  88, 110, 1, 1'b0);
        run_phase(511, 15, 15, 60,  0, 1'b0);
        run_phase($urandom_range(1, 24), 0,  0,  110, 2, 1'b0);
        run_phase($urandom_range(1, 24), 88, 0,  110, 0, 1'b0);
        run_phase($urandom_range(2, 64), 0,  88, 110, 1, 1'b0);
        run_phase(300, 15, 15, 50,  2, 1'b0);
        run_phase($urandom_range(1, 12), 0,  0,  110, 0, 1'b0);
        run_phase($urandom_range(1, 12), 15, 15, 110, 1, 1'b0);
        wait_idle();

        $display("ran %0d loads and %0d queries over %0d table-size settings",
                 loads_seen, queries_seen, cfg_writes);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_results_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
